// ===== hdl/mmul_pkg.sv =====
// ----------------------------------------------------------------------------
// mmul_pkg - shared types and constants of the matrix multiply core
// Command, status and register codes, the input and result word layouts and
// the control word that travels with the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mmul_pkg;

    // Default sizing
    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of a dimension register and of the loop counters
    localparam int DIM_W = 4;

    // Commands
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] elem_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] product_value;
        logic [1:0]         status;
        logic               overflow;
        logic               last;
    } out_word_t;

    // Tag that follows one operand pair through the MAC pipeline
    typedef struct packed {
        logic       valid;
        logic       first;    // first term of a dot product
        logic       last_k;   // final term of a dot product
        logic [2:0] row;
        logic [2:0] col;
        logic       last;     // final element of the run
    } mac_ctrl_t;

endpackage

// ===== hdl/mmul_mac.sv =====
// ----------------------------------------------------------------------------
// mmul_mac - shared multiply-accumulate unit
// Registered multiply, full-precision accumulate, then arithmetic shift by
// the fraction width and saturation into one result word per dot product.
// ----------------------------------------------------------------------------
module mmul_mac #(
    parameter int MAX_DIM    = mmul_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mmul_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mmul_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmul_pkg::mac_ctrl_t          ctrl,
    input  logic signed [DATA_WIDTH-1:0] a_data,
    input  logic signed [DATA_WIDTH-1:0] b_data,
    output logic                         res_valid,
    output mmul_pkg::out_word_t          res
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    mmul_pkg::mac_ctrl_t         ctrl2_reg;
    mmul_pkg::mac_ctrl_t         ctrl3_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     shifted;
    logic [ACC_W-DATA_WIDTH:0]   upper;
    logic                        ovf;
    logic signed [DATA_WIDTH-1:0] sat;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    mmul_pkg::out_word_t         res_reg;

    // Restart the sum on the first term of each dot product
    assign acc_next = (ctrl2_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    // Drop the fraction bits, then clamp to the element range
    assign shifted = acc_reg >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:DATA_WIDTH-1];
    assign ovf     = !((&upper) || (~|upper));
    assign sat     = ovf ? (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX)
                         : shifted[DATA_WIDTH-1:0];

    assign res_valid_next = ctrl3_reg.valid && ctrl3_reg.last_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg     <= '0;
            ctrl3_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl2_reg     <= ctrl;
            ctrl3_reg     <= ctrl2_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= PROD_W'(a_data) * PROD_W'(b_data);
        end
        if (ctrl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (res_valid_next)
        begin
            res_reg.out_row       <= ctrl3_reg.row;
            res_reg.out_col       <= ctrl3_reg.col;
            res_reg.product_value <= 32'(sat);
            res_reg.status        <= mmul_pkg::STAT_OK;
            res_reg.overflow      <= ovf;
            res_reg.last          <= ctrl3_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_core - signed fixed-point matrix multiply engine
// Holds matrices A and B in two on-chip stores and, on a compute command,
// streams out C = A * B in row-major order through one shared MAC unit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Word
//  --------  ------------------------  ---------------------------------------
//  command   start / busy              item   (command, row, col, value)
//  result    result_valid (strobe)     result (row, col, value, status, ...)
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data (4-bit dimension)
//
//  A load word produces nothing. A compute word issues
//  a_rows * b_cols * a_cols operand pairs, one per cycle, through the
//  pipeline stages store read, multiply, accumulate and saturate of the
//  single MAC unit. A bad size or dimension mismatch gives
//  one result in the cycle after start, with no busy period.
//  Reset is asynchronous; the stores are not cleared and must be loaded
//  before use. Results are shown for one cycle each and cannot be stalled.
// ----------------------------------------------------------------------------
module matrix_multiply_core #(
    parameter int MAX_DIM    = mmul_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mmul_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mmul_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  mmul_pkg::in_word_t            item,
    // result channel
    output logic                          result_valid,
    output mmul_pkg::out_word_t           result,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [mmul_pkg::DIM_W-1:0]    cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = mmul_pkg::DIM_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Dimension registers
    logic [DW-1:0] a_rows_reg;
    logic [DW-1:0] a_cols_reg;
    logic [DW-1:0] b_rows_reg;
    logic [DW-1:0] b_cols_reg;

    // Loop counters: i over rows of C, j over columns, k over the inner sum
    logic [DW-1:0] i_reg, i_next;
    logic [DW-1:0] j_reg, j_next;
    logic [DW-1:0] k_reg, k_next;
    logic          last_i, last_j, last_k;

    // Operand stores
    logic signed [DATA_WIDTH-1:0] a_store [DEPTH];
    logic signed [DATA_WIDTH-1:0] b_store [DEPTH];
    logic signed [DATA_WIDTH-1:0] a_rd_reg;
    logic signed [DATA_WIDTH-1:0] b_rd_reg;
    logic [ADDR_W-1:0]            w_addr;
    logic [ADDR_W-1:0]            a_raddr;
    logic [ADDR_W-1:0]            b_raddr;

    logic accept;
    logic in_range;
    logic a_we;
    logic b_we;
    logic do_compute;
    logic size_ok;
    logic dims_match;
    logic issue;

    mmul_pkg::mac_ctrl_t ctrl1_reg;
    logic                mac_valid;
    mmul_pkg::out_word_t mac_res;

    // Error result, shown in the cycle after the compute word
    logic       err_valid_reg;
    logic [1:0] err_status_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DW'(1);
            a_cols_reg <= DW'(1);
            b_rows_reg <= DW'(1);
            b_cols_reg <= DW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mmul_pkg::REG_A_ROWS: a_rows_reg <= cfg_data;
                mmul_pkg::REG_A_COLS: a_cols_reg <= cfg_data;
                mmul_pkg::REG_B_ROWS: b_rows_reg <= cfg_data;
                mmul_pkg::REG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    assign in_range = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
    assign w_addr   = ADDR_W'(int'(item.row_index) * MAX_DIM + int'(item.col_index));

    always_comb
    begin
        a_we       = 1'b0;
        b_we       = 1'b0;
        do_compute = 1'b0;
        case (item.command)
            mmul_pkg::CMD_LOAD_A:  a_we       = accept && in_range;
            mmul_pkg::CMD_LOAD_B:  b_we       = accept && in_range;
            mmul_pkg::CMD_COMPUTE: do_compute = accept;
            default: ;
        endcase
    end

    // A dimension is usable when it is nonzero and fits the stores
    assign size_ok = (a_rows_reg != '0) && (int'(a_rows_reg) <= MAX_DIM)
                  && (a_cols_reg != '0) && (int'(a_cols_reg) <= MAX_DIM)
                  && (b_rows_reg != '0) && (int'(b_rows_reg) <= MAX_DIM)
                  && (b_cols_reg != '0) && (int'(b_cols_reg) <= MAX_DIM);
    assign dims_match = (a_cols_reg == b_rows_reg);

    // ------------------------------------------------------------------
    // Sequencer: walk k fastest, then j, then i; one operand pair a cycle
    // ------------------------------------------------------------------
    assign issue  = (state_reg == ST_ISSUE);
    assign last_k = (k_reg == a_cols_reg - DW'(1));
    assign last_j = (j_reg == b_cols_reg - DW'(1));
    assign last_i = (i_reg == a_rows_reg - DW'(1));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_compute && size_ok && dims_match)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                k_next = last_k ? '0 : k_reg + DW'(1);
                if (last_k)
                begin
                    j_next = last_j ? '0 : j_reg + DW'(1);
                    if (last_j)
                    begin
                        i_next = i_reg + DW'(1);
                        if (last_i)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // hold until the final element leaves the MAC
                if (mac_valid && mac_res.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            ctrl1_reg      <= '0;
            err_valid_reg  <= 1'b0;
            err_status_reg <= mmul_pkg::STAT_OK;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            // tag travels alongside the store read data
            ctrl1_reg.valid  <= issue;
            ctrl1_reg.first  <= (k_reg == '0);
            ctrl1_reg.last_k <= last_k;
            ctrl1_reg.row    <= i_reg[2:0];
            ctrl1_reg.col    <= j_reg[2:0];
            ctrl1_reg.last   <= last_i && last_j;
            err_valid_reg    <= do_compute && !(size_ok && dims_match);
            err_status_reg   <= size_ok ? mmul_pkg::STAT_MISMATCH : mmul_pkg::STAT_BAD_SIZE;
        end
    end

    // ------------------------------------------------------------------
    // Operand stores: one write port from loads, one registered read port
    // ------------------------------------------------------------------
    assign a_raddr = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_store[w_addr] <= item.elem_value[DATA_WIDTH-1:0];
        end
        if (b_we)
        begin
            b_store[w_addr] <= item.elem_value[DATA_WIDTH-1:0];
        end
        if (issue)
        begin
            a_rd_reg <= a_store[a_raddr];
            b_rd_reg <= b_store[b_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Shared MAC unit
    // ------------------------------------------------------------------
    mmul_mac #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl1_reg),
        .a_data    (a_rd_reg),
        .b_data    (b_rd_reg),
        .res_valid (mac_valid),
        .res       (mac_res)
    );

    // ------------------------------------------------------------------
    // Result port: error word and MAC words never overlap
    // ------------------------------------------------------------------
    assign result_valid = err_valid_reg || mac_valid;

    always_comb
    begin
        result = mac_res;
        if (err_valid_reg)
        begin
            result.out_row       = '0;
            result.out_col       = '0;
            result.product_value = '0;
            result.status        = err_status_reg;
            result.overflow      = 1'b0;
            result.last          = 1'b1;
        end
    end

endmodule

// ===== hdl/mmul_checker.sv =====
// ----------------------------------------------------------------------------
// mmul_checker - port-level checks of the matrix multiply core
// Watches the command, result and configuration ports over time.
// ----------------------------------------------------------------------------
module mmul_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input mmul_pkg::in_word_t         item,
    input logic                       result_valid,
    input mmul_pkg::out_word_t        result,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [1:0]                 cfg_index,
    input logic [mmul_pkg::DIM_W-1:0] cfg_data
);

    // A compute word either starts a run or answers at once with an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.command == mmul_pkg::CMD_COMPUTE)
        |=> (busy || (result_valid && result.last && result.status != mmul_pkg::STAT_OK)))
        else $error("compute word neither started a run nor reported an error");

    // The run ends with the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !busy)
        else $error("busy held after the last result word");

    // Loads and the unused command never produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.command != mmul_pkg::CMD_COMPUTE) |=> !result_valid)
        else $error("result word after a load");

    // Error words are single and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != mmul_pkg::STAT_OK)
        |-> (result.last && !result.overflow && result.product_value == '0
             && !busy))
        else $error("malformed error word");

    // Register writes land only with the core idle and carry known values
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> (!busy && !$isunknown({cfg_index, cfg_data})))
        else $error("register write while busy or with unknown index or data");

endmodule

bind matrix_multiply_core mmul_checker u_mmul_checker (.*);

// ===== bench/tb_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_multiply_core - self-checking bench for the matrix multiply core
// Loads A and B element by element, fires compute words and checks every
// product word against a behavioral GEMM that tracks the stores and the four
// dimension registers. Directed corner tests come first (saturation, bad
// sizes, inner mismatch, unused command), then randomized load/compute
// phases over many matrix shapes with random sender gaps.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 4;
    localparam int DIMS          = mmul_pkg::MAX_DIM_DEF;
    localparam int FRAC          = mmul_pkg::FRAC_BITS_DEF;
    localparam int ITEM_TARGET   = 340;       // loads and computes, directed ones included
    localparam int CALM_TAIL     = 60;        // words at the end sent with no gaps
    localparam int SETTLE_CYCLES = 8;         // pipeline depth plus margin
    localparam int DRAIN_LIMIT   = 4000;
    localparam longint TIMEOUT_NS = 64'd40_000_000;

    // Command code with no function; the core must swallow it silently
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Saturation bounds of a Q16.16 result, held at accumulator width
    localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

    typedef enum int {SHAPE_SMALL, SHAPE_FULL, SHAPE_BAD, SHAPE_MISMATCH} shape_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    mmul_pkg::in_word_t          cmd_word;
    logic                        result_valid;
    mmul_pkg::out_word_t         res_word;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index;
    logic [mmul_pkg::DIM_W-1:0]  cfg_data;

    // Shadow copy of the core: both stores, which entries hold data, and
    // the dimension registers indexed by their register code.
    logic signed [31:0]          a_mem [DIMS*DIMS];
    logic signed [31:0]          b_mem [DIMS*DIMS];
    bit                          a_written [DIMS*DIMS];
    bit                          b_written [DIMS*DIMS];
    logic [mmul_pkg::DIM_W-1:0]  dim_reg [4];

    // Product words still owed by the core, oldest first
    mmul_pkg::out_word_t pending_q [$];

    int fail_count = 0;
    int items_sent = 0;
    bit idle_on    = 1'b0;

    matrix_multiply_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (cmd_word),
        .result_valid (result_valid),
        .result       (res_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("[matrix_multiply_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Failure bookkeeping: show the first ten, count the rest
    // ------------------------------------------------------------------------
    function automatic void log_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Behavioral GEMM: queue the words one compute command must produce.
    // Bad size wins over inner mismatch; both give a single marked word.
    // ------------------------------------------------------------------------
    function automatic void predict_gemm();
        mmul_pkg::out_word_t w;
        logic signed [71:0]  acc;
        logic signed [71:0]  scaled;
        int                  ar;
        int                  ac;
        int                  bc;
        bit                  bad;

        bad = 1'b0;
        foreach (dim_reg[n])
            if (dim_reg[n] == 0 || dim_reg[n] > DIMS)
                bad = 1'b1;

        w = '0;
        if (bad || dim_reg[mmul_pkg::REG_A_COLS] != dim_reg[mmul_pkg::REG_B_ROWS])
        begin
            w.status = bad ? mmul_pkg::STAT_BAD_SIZE : mmul_pkg::STAT_MISMATCH;
            w.last   = 1'b1;
            pending_q.push_back(w);
            return;
        end

        ar = dim_reg[mmul_pkg::REG_A_ROWS];
        ac = dim_reg[mmul_pkg::REG_A_COLS];
        bc = dim_reg[mmul_pkg::REG_B_COLS];
        for (int i = 0; i < ar; i++)
        begin
            for (int j = 0; j < bc; j++)
            begin
                // Sum at full width: eight 64-bit products need 67 bits
                acc = '0;
                for (int k = 0; k < ac; k++)
                    acc = acc + a_mem[i*DIMS + k] * b_mem[k*DIMS + j];
                // Arithmetic shift truncates toward minus infinity
                scaled = acc >>> FRAC;
                w = '0;
                w.out_row = 3'(i);
                w.out_col = 3'(j);
                w.status  = mmul_pkg::STAT_OK;
                if (scaled > Q_MAX)
                begin
                    w.product_value = Q_MAX[31:0];
                    w.overflow      = 1'b1;
                end
                else if (scaled < Q_MIN)
                begin
                    w.product_value = Q_MIN[31:0];
                    w.overflow      = 1'b1;
                end
                else
                begin
                    w.product_value = scaled[31:0];
                end
                w.last = (i == ar - 1) && (j == bc - 1);
                pending_q.push_back(w);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every strobed word must match the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        mmul_pkg::out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected word row %0d col %0d val %h st %0d",
                    res_word.out_row, res_word.out_col, res_word.product_value,
                    res_word.status));
            end
            else
            begin
                want = pending_q.pop_front();
                if (res_word.out_row !== want.out_row ||
                    res_word.out_col !== want.out_col ||
                    res_word.product_value !== want.product_value ||
                    res_word.status !== want.status ||
                    res_word.overflow !== want.overflow ||
                    res_word.last !== want.last)
                    log_mismatch($sformatf(
                        "exp r%0d c%0d %h st%0d ov%b l%b, got r%0d c%0d %h st%0d ov%b l%b",
                        want.out_row, want.out_col, want.product_value, want.status,
                        want.overflow, want.last, res_word.out_row, res_word.out_col,
                        res_word.product_value, res_word.status, res_word.overflow,
                        res_word.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------

    // Hold start low; n sets the length of the pause
    task automatic pause_sender(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one word at the falling edge, hold it until start meets a low
    // busy at a rising edge, then update the shadow model. Start stays high
    // so the next word can follow back to back.
    task automatic send_word(mmul_pkg::in_word_t w);
        int addr;
        if (idle_on && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 12));
        @(negedge clk);
        start    <= 1'b1;
        cmd_word <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        addr = {w.row_index, w.col_index};
        case (w.command)
            mmul_pkg::CMD_LOAD_A:
            begin
                a_mem[addr]     = w.elem_value;
                a_written[addr] = 1'b1;
            end
            mmul_pkg::CMD_LOAD_B:
            begin
                b_mem[addr]     = w.elem_value;
                b_written[addr] = 1'b1;
            end
            mmul_pkg::CMD_COMPUTE: predict_gemm();
            default: ;
        endcase
        if (w.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_load(logic [1:0] cmd, int r, int c, logic [31:0] v);
        mmul_pkg::in_word_t w;
        w.command    = cmd;
        w.row_index  = 3'(r);
        w.col_index  = 3'(c);
        w.elem_value = v;
        send_word(w);
    endtask

    // Position and value fields are don't-care on compute; toggle them anyway
    task automatic send_compute();
        mmul_pkg::in_word_t w;
        w.command    = mmul_pkg::CMD_COMPUTE;
        w.row_index  = 3'($urandom_range(0, 7));
        w.col_index  = 3'($urandom_range(0, 7));
        w.elem_value = $urandom();
        send_word(w);
    endtask

    // Drop start, wait for every owed word and for busy to fall, then let
    // the pipeline run dry before anything touches the registers.
    task automatic settle();
        int waited;
        @(negedge clk);
        start  <= 1'b0;
        waited = 0;
        while ((pending_q.size() != 0 || busy) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration channel: written only with the core idle
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [mmul_pkg::DIM_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        dim_reg[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mix of full-range words, small Q16.16 values and saturation corners
    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h0004_0000);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0001_0000;
                    default: v = 32'h0;
                endcase
                return v;
            end
            default: v = $urandom_range(0, 32'h0100_0000);
        endcase
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Load somewhere inside the region in use, now and then anywhere,
    // with an occasional unused command as noise.
    task automatic send_random_load();
        mmul_pkg::in_word_t w;
        int                 rmax;
        int                 cmax;
        w.command = $urandom_range(0, 1) ? mmul_pkg::CMD_LOAD_B : mmul_pkg::CMD_LOAD_A;
        if (w.command == mmul_pkg::CMD_LOAD_A)
        begin
            rmax = dim_reg[mmul_pkg::REG_A_ROWS];
            cmax = dim_reg[mmul_pkg::REG_A_COLS];
        end
        else
        begin
            rmax = dim_reg[mmul_pkg::REG_B_ROWS];
            cmax = dim_reg[mmul_pkg::REG_B_COLS];
        end
        if (rmax == 0 || rmax > DIMS || $urandom_range(0, 4) == 0)
            rmax = DIMS;
        if (cmax == 0 || cmax > DIMS || $urandom_range(0, 4) == 0)
            cmax = DIMS;
        if ($urandom_range(0, 9) == 0)
            w.command = CMD_UNUSED;
        w.row_index  = 3'($urandom_range(0, rmax - 1));
        w.col_index  = 3'($urandom_range(0, cmax - 1));
        w.elem_value = rand_elem();
        send_word(w);
    endtask

    // Load every entry the next compute will read that holds no data yet;
    // an unwritten entry must never be read.
    task automatic fill_missing();
        for (int i = 0; i < dim_reg[mmul_pkg::REG_A_ROWS]; i++)
            for (int k = 0; k < dim_reg[mmul_pkg::REG_A_COLS]; k++)
                if (!a_written[i*DIMS + k])
                    send_load(mmul_pkg::CMD_LOAD_A, i, k, rand_elem());
        for (int k = 0; k < dim_reg[mmul_pkg::REG_B_ROWS]; k++)
            for (int j = 0; j < dim_reg[mmul_pkg::REG_B_COLS]; j++)
                if (!b_written[k*DIMS + j])
                    send_load(mmul_pkg::CMD_LOAD_B, k, j, rand_elem());
    endtask

    // One phase: set a shape, load random content, compute once or twice
    task automatic run_phase(shape_t shape);
        int d [4];
        int which;
        bit ok;
        d[mmul_pkg::REG_A_ROWS] = $urandom_range(1, 4);
        d[mmul_pkg::REG_A_COLS] = $urandom_range(1, 4);
        d[mmul_pkg::REG_B_COLS] = $urandom_range(1, 4);
        case (shape)
            SHAPE_FULL:
            begin
                d[mmul_pkg::REG_A_ROWS] = DIMS;
                d[mmul_pkg::REG_A_COLS] = $urandom_range(1, DIMS);
                d[mmul_pkg::REG_B_COLS] = DIMS;
            end
            SHAPE_MISMATCH:
            begin
                d[mmul_pkg::REG_A_ROWS] = $urandom_range(1, DIMS);
                d[mmul_pkg::REG_A_COLS] = $urandom_range(1, DIMS);
                d[mmul_pkg::REG_B_COLS] = $urandom_range(1, DIMS);
            end
            default: ;
        endcase
        d[mmul_pkg::REG_B_ROWS] = d[mmul_pkg::REG_A_COLS];
        if (shape == SHAPE_MISMATCH)
            d[mmul_pkg::REG_B_ROWS] =
                ((d[mmul_pkg::REG_A_COLS] - 1 + $urandom_range(1, DIMS - 1)) % DIMS) + 1;
        if (shape == SHAPE_BAD)
        begin
            which    = $urandom_range(0, 3);
            d[which] = $urandom_range(0, 1) ? 0 : $urandom_range(DIMS + 1, 15);
        end
        for (int n = 0; n < 4; n++)
            write_reg(2'(n), mmul_pkg::DIM_W'(d[n]));

        ok = (shape == SHAPE_SMALL || shape == SHAPE_FULL);
        repeat ($urandom_range(0, 16)) send_random_load();
        if (ok)
            fill_missing();
        send_compute();
        // Second round on the same shape: partial reload, then compute again
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(0, 6)) send_random_load();
            if (ok)
                fill_missing();
            send_compute();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // 1x1 at reset sizes: saturation both ways, truncation of small negatives
    task automatic test_unit_extremes();
        logic [31:0] lhs [5];
        logic [31:0] rhs [5];
        lhs = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000};
        rhs = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hfffe_0000};
        for (int n = 0; n < 5; n++)
        begin
            send_load(mmul_pkg::CMD_LOAD_A, 0, 0, lhs[n]);
            send_load(mmul_pkg::CMD_LOAD_B, 0, 0, rhs[n]);
            send_compute();
        end
    endtask

    // Zero in each register in turn, then values above the maximum size
    task automatic test_size_errors();
        for (int n = 0; n < 4; n++)
        begin
            write_reg(2'(n), '0);
            send_compute();
            write_reg(2'(n), mmul_pkg::DIM_W'(1));
        end
        write_reg(mmul_pkg::REG_B_COLS, mmul_pkg::DIM_W'(15));
        send_compute();
        write_reg(mmul_pkg::REG_B_COLS, mmul_pkg::DIM_W'(DIMS + 1));
        send_compute();
        write_reg(mmul_pkg::REG_B_COLS, mmul_pkg::DIM_W'(DIMS));
    endtask

    // Valid sizes but A columns differ from B rows
    task automatic test_mismatch();
        write_reg(mmul_pkg::REG_A_COLS, mmul_pkg::DIM_W'(DIMS));
        write_reg(mmul_pkg::REG_B_ROWS, mmul_pkg::DIM_W'(DIMS - 1));
        send_compute();
    endtask

    // Unused command must produce nothing; the compute after it still checks
    task automatic test_unused_command();
        mmul_pkg::in_word_t w;
        w.command    = CMD_UNUSED;
        w.row_index  = 3'd7;
        w.col_index  = 3'd7;
        w.elem_value = 32'hffff_ffff;
        send_word(w);
        send_compute();
    endtask

    // Random phases; one full 8x8 output first, gaps off near the end
    task automatic test_random_mix();
        int     pick;
        shape_t shape;
        idle_on = 1'b1;
        run_phase(SHAPE_FULL);
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                shape = SHAPE_FULL;
            else if (pick <= 2)
                shape = SHAPE_BAD;
            else if (pick <= 4)
                shape = SHAPE_MISMATCH;
            else
                shape = SHAPE_SMALL;
            idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            run_phase(shape);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd_word  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (dim_reg[n])
            dim_reg[n] = mmul_pkg::DIM_W'(1);
        foreach (a_written[n])
        begin
            a_written[n] = 1'b0;
            b_written[n] = 1'b0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unit_extremes();
        test_size_errors();
        test_mismatch();
        test_unused_command();
        test_random_mix();

        // Drain, then flag anything the core never delivered
        settle();
        if (pending_q.size() != 0)
            log_mismatch($sformatf("%0d product words never arrived", pending_q.size()));

        if (fail_count == 0)
            $display("[matrix_multiply_core] OK");
        else
            $display("[matrix_multiply_core] ERROR");
        $finish;
    end

endmodule
